>>> hw/rtl/http_request_line_checker_assert.svh
// ----------------------------------------------------------------------------
// http_request_line_checker_assert.svh
// assertion macros shared by the request line checker rtl
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HRLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// types, status codes and character constants of the request line checker
// ----------------------------------------------------------------------------
`default_nettype none

package hrlc_pkg;

    localparam int unsigned DEF_MAX_URI_LEN = 255;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_NOSLASH = 3'd2;
    localparam logic [2:0] ST_NOTGET  = 3'd3;
    localparam logic [2:0] ST_VERSION = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] METHOD_LEN = 3'd3;
    localparam logic [3:0] PROTO_LEN  = 4'd8;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] uri_length;
        logic       uri_is_root;
    } t_result;

    // "GET"
    function automatic logic [7:0] method_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // "HTTP/1.1"
    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hrlc_line_fsm.sv
// ----------------------------------------------------------------------------
// hrlc_line_fsm
// per-byte field tracker of the request line and result decision
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_line_fsm #(
    parameter int unsigned MAX_URI_LEN = hrlc_pkg::DEF_MAX_URI_LEN
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire  [7:0]           i_byte,
    input  wire                  i_end,
    output logic                 o_res_valid,
    output hrlc_pkg::t_result    o_res
);

    localparam logic [7:0] URI_CAP = 8'((MAX_URI_LEN < 255) ? MAX_URI_LEN : 255);

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI,
        PH_PROTO,
        PH_AFTER_CR,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_method_idx, n_method_idx;
    logic        r_method_ok, n_method_ok;
    logic [7:0]  r_uri_cnt, n_uri_cnt;
    logic        r_uri_slash, n_uri_slash;
    logic [3:0]  r_proto_idx, n_proto_idx;
    logic        r_proto_ok, n_proto_ok;

    hrlc_pkg::t_result w_good;
    hrlc_pkg::t_result w_bad;

    // result built from the fields seen so far
    always_comb begin
        w_good.status = hrlc_pkg::ST_OK;
        if (!(r_uri_cnt != 8'd0 && r_uri_slash)) begin
            w_good.status = hrlc_pkg::ST_NOSLASH;
        end
        if (!(r_method_ok && r_method_idx == hrlc_pkg::METHOD_LEN)) begin
            w_good.status = hrlc_pkg::ST_NOTGET;
        end
        if (!(r_proto_ok && r_proto_idx == hrlc_pkg::PROTO_LEN)) begin
            w_good.status = hrlc_pkg::ST_VERSION;
        end
        w_good.uri_length  = r_uri_cnt;
        w_good.uri_is_root = (r_uri_cnt == 8'd1) && r_uri_slash;

        w_bad.status      = hrlc_pkg::ST_BAD;
        w_bad.uri_length  = 8'd0;
        w_bad.uri_is_root = 1'b0;
    end

    always_comb begin
        n_phase      = r_phase;
        n_method_idx = r_method_idx;
        n_method_ok  = r_method_ok;
        n_uri_cnt    = r_uri_cnt;
        n_uri_slash  = r_uri_slash;
        n_proto_idx  = r_proto_idx;
        n_proto_ok   = r_proto_ok;
        o_res_valid  = 1'b0;
        o_res        = w_bad;

        if (r_phase != PH_DONE) begin
            if (i_byte == hrlc_pkg::CH_NUL) begin
                o_res_valid = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_METHOD: begin
                        if (i_byte == hrlc_pkg::CH_SP) begin
                            n_phase = PH_URI;
                        end else if (r_method_idx < hrlc_pkg::METHOD_LEN) begin
                            if (i_byte != hrlc_pkg::method_char(r_method_idx[1:0])) begin
                                n_method_ok = 1'b0;
                            end
                            n_method_idx = r_method_idx + 3'd1;
                        end else begin
                            n_method_ok  = 1'b0;
                            n_method_idx = 3'd4;
                        end
                    end
                    PH_URI: begin
                        if (i_byte == hrlc_pkg::CH_SP) begin
                            n_phase = PH_PROTO;
                        end else begin
                            if (r_uri_cnt == 8'd0) begin
                                n_uri_slash = (i_byte == hrlc_pkg::CH_SLASH);
                            end
                            if (r_uri_cnt < URI_CAP) begin
                                n_uri_cnt = r_uri_cnt + 8'd1;
                            end
                        end
                    end
                    PH_PROTO: begin
                        if (i_byte == hrlc_pkg::CH_CR) begin
                            n_phase = PH_AFTER_CR;
                        end else if (i_byte == hrlc_pkg::CH_LF) begin
                            o_res_valid = 1'b1;
                            o_res       = w_good;
                        end else if (r_proto_idx < hrlc_pkg::PROTO_LEN) begin
                            if (i_byte != hrlc_pkg::proto_char(r_proto_idx[2:0])) begin
                                n_proto_ok = 1'b0;
                            end
                            n_proto_idx = r_proto_idx + 4'd1;
                        end else begin
                            n_proto_ok  = 1'b0;
                            n_proto_idx = 4'd9;
                        end
                    end
                    PH_AFTER_CR: begin
                        o_res_valid = 1'b1;
                        if (i_byte == hrlc_pkg::CH_LF) begin
                            o_res = w_good;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end

            // unterminated at the end of the buffer
            if (!o_res_valid && i_end) begin
                o_res_valid = 1'b1;
                o_res       = w_bad;
            end
        end

        if (i_end) begin
            n_phase      = PH_METHOD;
            n_method_idx = 3'd0;
            n_method_ok  = 1'b1;
            n_uri_cnt    = 8'd0;
            n_uri_slash  = 1'b0;
            n_proto_idx  = 4'd0;
            n_proto_ok   = 1'b1;
        end else if (o_res_valid) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_METHOD;
            r_method_idx <= 3'd0;
            r_method_ok  <= 1'b1;
            r_uri_cnt    <= 8'd0;
            r_uri_slash  <= 1'b0;
            r_proto_idx  <= 4'd0;
            r_proto_ok   <= 1'b1;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_method_idx <= n_method_idx;
            r_method_ok  <= n_method_ok;
            r_uri_cnt    <= n_uri_cnt;
            r_uri_slash  <= n_uri_slash;
            r_proto_idx  <= n_proto_idx;
            r_proto_ok   <= n_proto_ok;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/http_request_line_checker.sv
// ----------------------------------------------------------------------------
// http_request_line_checker
// checks the request line of an http request, one byte per word
// ----------------------------------------------------------------------------
// usage:
//   slave side carries one request byte per word, tlast marks the last byte
//   of a receive buffer. master side carries one result word per request
//   line: status, uri length and a root flag.
//   each accepted byte lands in an input register; once the output register
//   is free it is run through the field tracker and any result is written
//   to the output register, which drives o_m_tvalid.
//   throughput is one byte per cycle, set by the single-byte field tracker,
//   while no result waits on a receiver that holds i_m_tready low.
//   bytes that produce no result pass through without using the output.
//   when the receiver holds i_m_tready low with a result waiting, one more
//   byte is taken into the input register, then o_s_tready drops until the
//   result is taken.
//   synchronous reset empties both registers and returns the tracker to
//   the start of a line.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_line_checker_assert.svh"

module http_request_line_checker #(
    parameter int unsigned MAX_URI_LEN = hrlc_pkg::DEF_MAX_URI_LEN
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tlast,   // buffer_end
    // master side
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [2:0] status, [10:3] uri_length, [11] uri_is_root
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;
    logic              r_out_valid;
    hrlc_pkg::t_result r_out;

    logic              w_out_free;
    logic              w_step;
    logic              w_res_valid;
    hrlc_pkg::t_result w_res;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    hrlc_line_fsm #(
        .MAX_URI_LEN (MAX_URI_LEN)
    ) u_line_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_step) begin
                r_out_valid <= w_res_valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.uri_is_root, r_out.uri_length, r_out.status};

    `HRLC_ASSERT_NEXT(a_res_reaches_out, i_clk, i_rst_n,
        w_step && w_res_valid, o_m_tvalid,
        "result from tracker not registered")
    `HRLC_ASSERT_NOW(a_full_blocks_in, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_m_tready, !o_s_tready,
        "input taken while both registers full")
    `HRLC_ASSERT_NOW(a_bad_clears_uri, i_clk, i_rst_n,
        o_m_tvalid && r_out.status == hrlc_pkg::ST_BAD,
        r_out.uri_length == 8'd0 && !r_out.uri_is_root,
        "bad line carries uri data")
    `HRLC_ASSERT_NOW(a_root_len_one, i_clk, i_rst_n,
        o_m_tvalid && r_out.uri_is_root, r_out.uri_length == 8'd1,
        "root flag without single-byte uri")

endmodule

`default_nettype wire
